>>> hw/rtl/assert_macros.svh
// Shared assertion macros. Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked property, disabled while reset is high.
`define ASSERT_DIS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property, checked in every cycle, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_DIS(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

>>> hw/rtl/aalr_pkg.sv
`timescale 1ns / 1ps

package aalr_pkg;

   localparam int COORD_BITS   = 10;
   localparam int COVER_BITS   = 8;
   localparam int FRAC_BITS    = 16;
   localparam int COLOUR_BITS  = 16;
   localparam int PIX_BITS     = COORD_BITS + 1;
   localparam int CVR_BITS     = COVER_BITS + 1;

   localparam logic ACT_START = 1'b0;
   localparam logic ACT_STEP  = 1'b1;

   typedef struct packed {
      logic                   action;
      logic [COORD_BITS-1:0]  start_x;
      logic [COORD_BITS-1:0]  end_x;
      logic [COORD_BITS-1:0]  start_y;
      logic [COORD_BITS-1:0]  end_y;
      logic [COLOUR_BITS-1:0] line_colour;
   } req_type;

   typedef struct packed {
      logic [PIX_BITS-1:0]    first_px_x;
      logic [PIX_BITS-1:0]    first_px_y;
      logic [CVR_BITS-1:0]    first_cover;
      logic [PIX_BITS-1:0]    second_px_x;
      logic [PIX_BITS-1:0]    second_px_y;
      logic [CVR_BITS-1:0]    second_cover;
      logic [COLOUR_BITS-1:0] pixel_colour;
      logic                   last_pair;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_WAIT,
      ST_DIV,
      ST_FINISH,
      ST_STEP
   } ctrl_state_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_END2,
      PH_INNER
   } phase_type;

   typedef struct packed {
      logic load_start;
      logic div_step;
      logic finish;
      logic emit_end2;
      logic emit_inner;
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;
      logic end2_last;
      logic inner_last;
   } dp_status_type;

endpackage

>>> hw/rtl/aalr_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module aalr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_action,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  aalr_pkg::dp_status_type status,
   output aalr_pkg::dp_cmd_type    cmd
);

   aalr_pkg::ctrl_state_type state_ff, state_in;
   aalr_pkg::phase_type      phase_ff, phase_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     out_free;
   logic                     out_load;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign out_load  = cmd.finish || cmd.emit_end2 || cmd.emit_inner;
   assign req_stall = (state_ff != aalr_pkg::ST_WAIT);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= aalr_pkg::ST_WAIT;
         phase_ff     <= aalr_pkg::PH_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      cmd      = '0;
      case (state_ff)
         aalr_pkg::ST_WAIT: begin
            if (req_valid) begin
               if (req_action == aalr_pkg::ACT_START) begin
                  cmd.load_start = 1'b1;
                  state_in       = aalr_pkg::ST_DIV;
               end else begin
                  state_in = aalr_pkg::ST_STEP;
               end
            end
         end
         aalr_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = aalr_pkg::ST_FINISH;
            end
         end
         aalr_pkg::ST_FINISH: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               phase_in   = aalr_pkg::PH_END2;
               state_in   = aalr_pkg::ST_WAIT;
            end
         end
         aalr_pkg::ST_STEP: begin
            case (phase_ff)
               aalr_pkg::PH_END2: begin
                  if (out_free) begin
                     cmd.emit_end2 = 1'b1;
                     phase_in      = status.end2_last ? aalr_pkg::PH_IDLE
                                                      : aalr_pkg::PH_INNER;
                     state_in      = aalr_pkg::ST_WAIT;
                  end
               end
               aalr_pkg::PH_INNER: begin
                  if (out_free) begin
                     cmd.emit_inner = 1'b1;
                     if (status.inner_last) begin
                        phase_in = aalr_pkg::PH_IDLE;
                     end
                     state_in = aalr_pkg::ST_WAIT;
                  end
               end
               default: begin
                  // step with no line in progress: dropped
                  state_in = aalr_pkg::ST_WAIT;
               end
            endcase
         end
         default: begin
            state_in = aalr_pkg::ST_WAIT;
         end
      endcase
      rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);
   end

   `ASSERT_DIS(a_load_needs_room, clock, reset, out_load |-> out_free, "output overwritten while stalled")
   `ASSERT_DIS(a_finish_after_div, clock, reset, (state_ff == aalr_pkg::ST_FINISH) |-> (($past(state_ff) == aalr_pkg::ST_FINISH) || $past(status.div_done)), "finish entered before divide done")
   `ASSERT_DIS(a_inner_from_end2, clock, reset, ((phase_ff == aalr_pkg::PH_INNER) && ($past(phase_ff) != aalr_pkg::PH_INNER)) |-> ($past(phase_ff) == aalr_pkg::PH_END2), "interior phase entered without second endpoint")

endmodule

>>> hw/rtl/aalr_datapath.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module aalr_datapath #(
   parameter int FRAC_BITS = aalr_pkg::FRAC_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  aalr_pkg::req_type       req_payload,
   input  aalr_pkg::dp_cmd_type    cmd,
   output aalr_pkg::dp_status_type status,
   output aalr_pkg::rsp_type       rsp_payload
);

   localparam int CB     = aalr_pkg::COORD_BITS;
   localparam int CVB    = aalr_pkg::COVER_BITS;
   localparam int CVR_W  = aalr_pkg::CVR_BITS;
   localparam int PIX_W  = aalr_pkg::PIX_BITS;
   localparam int COL_W  = aalr_pkg::COLOUR_BITS;
   localparam int ACC_W  = CB + FRAC_BITS + 1;
   localparam int GRAD_W = FRAC_BITS + 2;
   localparam int QUO_W  = FRAC_BITS + 1;
   localparam int CNT_W  = $clog2(FRAC_BITS + 1);

   localparam logic [GRAD_W-1:0] GRAD_ONE   = GRAD_W'(1) << FRAC_BITS;
   localparam logic [CVR_W-1:0]  COVER_FULL = CVR_W'(1) << CVB;
   localparam logic [CVR_W-1:0]  COVER_HALF = CVR_W'(1) << (CVB - 1);

   function automatic logic [ACC_W-1:0] grad_ext(input logic [GRAD_W-1:0] g);
      return {{(ACC_W - GRAD_W){g[GRAD_W-1]}}, g};
   endfunction

   // line state
   logic              steep_ff;
   logic [CB-1:0]     major_pos_ff;
   logic [CB-1:0]     major_end_ff;
   logic [CB-1:0]     minor_end_ff;
   logic [CB-1:0]     minor_start_ff;
   logic [COL_W-1:0]  colour_ff;
   logic [ACC_W-1:0]  acc_ff;
   logic [GRAD_W-1:0] grad_ff;
   // divider
   logic              neg_ff;
   logic              zero_ff;
   logic [CB-1:0]     div_ff;
   logic [CB-1:0]     rem_ff;
   logic [QUO_W-1:0]  quot_ff;
   logic [CNT_W-1:0]  cnt_ff;
   aalr_pkg::rsp_type out_ff;

   // start setup
   logic [CB-1:0] ax, bx, ay, by, adx, ady;
   logic [CB-1:0] p0, p1, q0, q1, s0, s1, t0, t1;
   logic          steep;
   logic [CB-1:0] span, mag;

   always_comb begin
      ax    = req_payload.start_x;
      bx    = req_payload.end_x;
      ay    = req_payload.start_y;
      by    = req_payload.end_y;
      adx   = (ax > bx) ? ax - bx : bx - ax;
      ady   = (ay > by) ? ay - by : by - ay;
      steep = ady > adx;
      s0    = steep ? ay : ax;
      s1    = steep ? by : bx;
      t0    = steep ? ax : ay;
      t1    = steep ? bx : by;
      if (s0 > s1) begin
         p0 = s1;
         p1 = s0;
         q0 = t1;
         q1 = t0;
      end else begin
         p0 = s0;
         p1 = s1;
         q0 = t0;
         q1 = t1;
      end
      span = p1 - p0;
      mag  = (q1 >= q0) ? q1 - q0 : q0 - q1;
   end

   // restoring divide, one quotient bit per cycle; the first bit is the integer bit
   logic [CB:0]       trial;
   logic [CB:0]       diff;
   logic              ge;
   logic [CB-1:0]     rem_in;
   logic [QUO_W-1:0]  quot_in;

   always_comb begin
      trial   = (cnt_ff == '0) ? {1'b0, rem_ff} : {rem_ff, 1'b0};
      diff    = trial - {1'b0, div_ff};
      ge      = trial >= {1'b0, div_ff};
      rem_in  = ge ? diff[CB-1:0] : trial[CB-1:0];
      quot_in = {quot_ff[QUO_W-2:0], ge};
   end

   logic [GRAD_W-1:0] mag_q, grad_calc;
   logic [ACC_W-1:0]  acc_init;

   always_comb begin
      mag_q     = {1'b0, quot_ff};
      if (zero_ff) begin
         grad_calc = GRAD_ONE;
      end else begin
         grad_calc = neg_ff ? (~mag_q + GRAD_W'(1)) : mag_q;
      end
      acc_init  = {1'b0, minor_start_ff, FRAC_BITS'(0)} + grad_ext(grad_calc);
   end

   // step status
   logic [CB-1:0] end_gap;
   logic [CB:0]   pos_next;
   logic          end2_last;
   logic          inner_last;
   logic [CVB-1:0] frac_cover;

   always_comb begin
      end_gap    = major_end_ff - major_pos_ff;
      end2_last  = end_gap <= CB'(1);
      pos_next   = {1'b0, major_pos_ff} + (CB + 1)'(1);
      inner_last = pos_next >= {1'b0, major_end_ff};
      frac_cover = acc_ff[FRAC_BITS-1 -: CVB];
   end

   assign status.div_done   = (cnt_ff == CNT_W'(FRAC_BITS));
   assign status.end2_last  = end2_last;
   assign status.inner_last = inner_last;

   // result pair
   logic [CB-1:0]      em_major, em_minor;
   logic [CVR_W-1:0]   em_c1, em_c2;
   logic               em_last;
   logic [PIX_W-1:0]   major_px, minor_px, minor_px1;
   aalr_pkg::rsp_type  pkt;

   always_comb begin
      em_major = major_pos_ff;
      em_minor = minor_start_ff;
      em_c1    = COVER_HALF;
      em_c2    = '0;
      em_last  = 1'b0;
      if (cmd.emit_end2) begin
         em_major = major_end_ff;
         em_minor = minor_end_ff;
         em_last  = end2_last;
      end else if (cmd.emit_inner) begin
         em_minor = acc_ff[FRAC_BITS +: CB];
         em_c1    = COVER_FULL - {1'b0, frac_cover};
         em_c2    = {1'b0, frac_cover};
         em_last  = inner_last;
      end
      major_px  = {1'b0, em_major};
      minor_px  = {1'b0, em_minor};
      minor_px1 = minor_px + PIX_W'(1);
      if (steep_ff) begin
         pkt.first_px_x  = minor_px;
         pkt.first_px_y  = major_px;
         pkt.second_px_x = minor_px1;
         pkt.second_px_y = major_px;
      end else begin
         pkt.first_px_x  = major_px;
         pkt.first_px_y  = minor_px;
         pkt.second_px_x = major_px;
         pkt.second_px_y = minor_px1;
      end
      pkt.first_cover  = em_c1;
      pkt.second_cover = em_c2;
      pkt.pixel_colour = colour_ff;
      pkt.last_pair    = em_last;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_start) begin
         steep_ff       <= steep;
         major_pos_ff   <= p0;
         major_end_ff   <= p1;
         minor_start_ff <= q0;
         minor_end_ff   <= q1;
         colour_ff      <= req_payload.line_colour;
         neg_ff         <= q1 < q0;
         zero_ff        <= span == '0;
         div_ff         <= span;
         rem_ff         <= mag;
         quot_ff        <= '0;
         cnt_ff         <= '0;
      end
      if (cmd.div_step) begin
         rem_ff  <= rem_in;
         quot_ff <= quot_in;
         cnt_ff  <= cnt_ff + CNT_W'(1);
      end
      if (cmd.finish) begin
         grad_ff <= grad_calc;
         acc_ff  <= acc_init;
      end
      if (cmd.emit_end2 && !end2_last) begin
         major_pos_ff <= major_pos_ff + CB'(1);
      end
      if (cmd.emit_inner) begin
         acc_ff       <= acc_ff + grad_ext(grad_ff);
         major_pos_ff <= major_pos_ff + CB'(1);
      end
      if (cmd.finish || cmd.emit_end2 || cmd.emit_inner) begin
         out_ff <= pkt;
      end
   end

   assign rsp_payload = out_ff;

   `ASSERT_DIS(a_rem_below_div, clock, reset, (cmd.div_step && !zero_ff && (cnt_ff != '0)) |-> (rem_ff < div_ff), "divider remainder not below divisor")

endmodule

>>> hw/rtl/antialiased_line_rasterizer_core.sv
`timescale 1ns / 1ps
// Channel | Direction | Payload            | Handshake
// req     | in        | aalr_pkg::req_type | req_valid / req_stall
// rsp     | out       | aalr_pkg::rsp_type | rsp_valid / rsp_stall
//
// Start item: accept, then the restoring divider forms the gradient one quotient
// bit per cycle, then the first endpoint pair is written to the output register.
// Step item: accept, then emit one pair; interior pairs take one accumulator add.
// A step with no line in progress produces no transfer on rsp.
// Reset clears the controller and output valid; line registers are loaded on start.
// The output register holds its pair while rsp_stall is high; a start can run its
// divide meanwhile, but no new pair is written until the register drains.

module antialiased_line_rasterizer_core #(
   parameter int FRAC_BITS = aalr_pkg::FRAC_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  aalr_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output aalr_pkg::rsp_type rsp_payload
);

   aalr_pkg::dp_cmd_type    cmd;
   aalr_pkg::dp_status_type status;

   aalr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_payload.action),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .status     (status),
      .cmd        (cmd)
   );

   aalr_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

endmodule
